// File: hw/rtl/pstd_pkg.sv
// Shared types and constants for the packet sequence and delay tracker.
// Used by pstd_alu and packet_sequence_delay_tracker_unit.
`timescale 1ns / 1ps

package pstd_pkg;

	// circular sequence space
	localparam int SEQ_W      = 12;
	localparam int SEQ_SPACE  = 1 << SEQ_W;
	localparam int HALF_SPACE = SEQ_SPACE / 2;

	localparam int HEADER_BYTES_DEF = 24;

	// field widths
	localparam int LEN_W   = 16;
	localparam int TOK_W   = 8;
	localparam int TIME_W  = 62;
	localparam int DLY_W   = 63;
	localparam int SUM_W   = 64;
	localparam int CNT_W   = 32;
	localparam int BYTES_W = 48;
	localparam int TMO_W   = 16;

	// timeout threshold in ns: timeout_ms * NS_PER_MS
	localparam int NS_PER_MS = 1000 * 1000;
	localparam int NSMS_W    = 20;
	localparam int THR_W     = TMO_W + NSMS_W;

	// shared adder: wide enough for (threshold - (delay - min)) without overflow
	localparam int ALU_W = 66;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOKEN   = 1'b0,
		CFG_TIMEOUT = 1'b1
	} cfg_idx_t;

	localparam int TOKEN_RESET   = 0;
	localparam int TIMEOUT_RESET = 1000;

	typedef enum logic [2:0] {
		V_IN_ORDER = 3'd0,
		V_REORDER  = 3'd1,
		V_DUP      = 3'd2,
		V_SHORT    = 3'd3,
		V_TOKEN    = 3'd4
	} verdict_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_CHK,
		ST_WALK,
		ST_SET1,
		ST_SET0,
		ST_ADV,
		ST_DLY,
		ST_DIFF,
		ST_TOUT,
		ST_MAX,
		ST_SUM,
		ST_BYTES,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/pstd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pstd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/pstd_alu.sv
// Shared add/subtract unit of the tracker, with sign flag of the result.
// Depends on pstd_pkg.
`timescale 1ns / 1ps

module pstd_alu
	import pstd_pkg::*;
(
	input  logic signed [ALU_W-1:0] a,
	input  logic signed [ALU_W-1:0] b,
	input  logic                    sub,
	output logic signed [ALU_W-1:0] res,
	output logic                    neg
);

	assign res = sub ? (a - b) : (a + b);
	assign neg = res[ALU_W-1];

endmodule

// File: hw/rtl/packet_sequence_delay_tracker_unit.sv
// Top level of the packet sequence and delay tracker.
// Depends on pstd_pkg, pstd_ram (seen bitmap) and pstd_alu (shared adder).
`timescale 1ns / 1ps

//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------------
//  in      | in_valid / in_ready         | packet_length, packet_token,
//          |                             | sequence_number, send_time, arrive_time
//  out     | out_valid / out_ready       | verdict, next_expected, counters, delays
//  cfg     | cfg_valid / cfg_ready (=1)  | cfg_index (0 token, 1 timeout_ms), cfg_data
//
//  After reset the seen bitmap is swept to zero, one entry a cycle, with in_ready
//  low. Config writes are taken at any time.
//  Short, wrong-token and duplicate requests go from the check straight to the
//  result. Accepted requests first walk the forward gap G (one bitmap clear per
//  cycle), then mark the number, then skip the run R of already seen numbers (one
//  bitmap read per cycle) before the delay stats.
//  Delay stats and the byte count go through one shared 66-bit adder, six passes.
//  A new request is taken while a result waits; the next result waits in the done
//  state until the result stage is free (out_ready).

module packet_sequence_delay_tracker_unit
	import pstd_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [LEN_W-1:0]             packet_length,
	input  logic [TOK_W-1:0]             packet_token,
	input  logic [SEQ_W-1:0]             sequence_number,
	input  logic [TIME_W-1:0]            send_time,
	input  logic [TIME_W-1:0]            arrive_time,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   verdict,
	output logic [SEQ_W-1:0]             next_expected,
	output logic [CNT_W-1:0]             accepted_count,
	output logic [BYTES_W-1:0]           accepted_bytes,
	output logic [CNT_W-1:0]             illegal_count,
	output logic [CNT_W-1:0]             reorder_count,
	output logic [CNT_W-1:0]             duplicate_count,
	output logic [CNT_W-1:0]             timeout_count,
	output logic signed [DLY_W-1:0]      lowest_delay,
	output logic signed [DLY_W-1:0]      highest_delay,
	output logic signed [SUM_W-1:0]      delay_sum,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	state_t state_q, state_d;

	// config
	logic [TOK_W-1:0] token_q;
	logic [TMO_W-1:0] timeout_q;

	// captured request
	logic [LEN_W-1:0]  len_q;
	logic [TOK_W-1:0]  tok_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TIME_W-1:0] send_q;
	logic [TIME_W-1:0] arr_q;

	// tracker state
	logic [SEQ_W-1:0]          exp_q;
	logic [SEQ_W-1:0]          ptr_q;
	logic [SEQ_W-1:0]          clr_q;
	logic [CNT_W-1:0]          acc_q;
	logic [BYTES_W-1:0]        bytes_q;
	logic [CNT_W-1:0]          illegal_q;
	logic [CNT_W-1:0]          reorder_q;
	logic [CNT_W-1:0]          dup_q;
	logic [CNT_W-1:0]          tout_q;
	logic signed [DLY_W-1:0]   dmin_q;
	logic signed [DLY_W-1:0]   dmax_q;
	logic signed [SUM_W-1:0]   dsum_q;

	// per-request scratch
	verdict_t                  verdict_q;
	logic                      first_q;
	logic signed [DLY_W-1:0]   delay_q;
	logic signed [ALU_W-1:0]   diff_q;
	logic [THR_W-1:0]          thr_q;

	// result stage
	logic                      out_valid_q;
	verdict_t                  o_verdict_q;
	logic [SEQ_W-1:0]          o_exp_q;
	logic [CNT_W-1:0]          o_acc_q;
	logic [BYTES_W-1:0]        o_bytes_q;
	logic [CNT_W-1:0]          o_illegal_q;
	logic [CNT_W-1:0]          o_reorder_q;
	logic [CNT_W-1:0]          o_dup_q;
	logic [CNT_W-1:0]          o_tout_q;
	logic signed [DLY_W-1:0]   o_dmin_q;
	logic signed [DLY_W-1:0]   o_dmax_q;
	logic signed [SUM_W-1:0]   o_dsum_q;

	// bitmap port
	logic             ram_we;
	logic [SEQ_W-1:0] ram_waddr;
	logic             ram_wdata;
	logic [SEQ_W-1:0] ram_raddr;
	logic             ram_rdata;

	// shared adder
	logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic                    alu_sub, alu_neg;

	// classification helpers
	logic             is_short, bad_token, do_walk, out_free;
	logic [SEQ_W-1:0] gap;
	logic [CNT_W-1:0] acc_inc;

	assign is_short  = len_q < LEN_W'(HEADER_BYTES);
	assign bad_token = tok_q != token_q;
	// forward jump below half a space (mod-space distance in 1..HALF-1)
	assign gap       = seq_q - exp_q;
	assign do_walk   = (gap != '0) && !gap[SEQ_W-1];
	assign acc_inc   = acc_q + CNT_W'(1);
	assign out_free  = !out_valid_q || out_ready;

	pstd_ram #(
		.WIDTH(1),
		.DEPTH(SEQ_SPACE)
	) u_seen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pstd_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sub(alu_sub),
		.res(alu_res),
		.neg(alu_neg)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == SEQ_W'(SEQ_SPACE - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHK;
			end
			ST_CHK: begin
				if (is_short || bad_token || ram_rdata) state_d = ST_DONE;
				else if (do_walk) state_d = ST_WALK;
				else state_d = ST_SET1;
			end
			ST_WALK: begin
				if (exp_q + SEQ_W'(1) == seq_q) state_d = ST_SET1;
			end
			ST_SET1:  state_d = ST_SET0;
			ST_SET0:  state_d = ST_ADV;
			ST_ADV: begin
				if (!ram_rdata) state_d = ST_DLY;
			end
			ST_DLY:   state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_TOUT;
			ST_TOUT:  state_d = ST_MAX;
			ST_MAX:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_BYTES;
			ST_BYTES: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_CLR;
		endcase
	end

	// per-state controls: in_ready, bitmap port, adder operands
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = seq_q;
		ram_wdata = 1'b0;
		ram_raddr = ptr_q + SEQ_W'(1);
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b1;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = sequence_number;
			end
			ST_WALK: begin
				// drop the stale mark half a space ahead of each skipped number
				ram_we    = 1'b1;
				ram_waddr = exp_q + SEQ_W'(HALF_SPACE);
			end
			ST_SET1: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
			end
			ST_SET0: begin
				ram_we    = 1'b1;
				ram_waddr = seq_q + SEQ_W'(HALF_SPACE);
				ram_raddr = seq_q + SEQ_W'(1);
			end
			ST_DLY: begin
				alu_a = ALU_W'(arr_q);
				alu_b = ALU_W'(send_q);
			end
			ST_DIFF: begin
				alu_a = ALU_W'(delay_q);
				alu_b = first_q ? ALU_W'(delay_q) : ALU_W'(dmin_q);
			end
			ST_TOUT: begin
				alu_a = ALU_W'(thr_q);
				alu_b = diff_q;
			end
			ST_MAX: begin
				alu_a = ALU_W'(dmax_q);
				alu_b = ALU_W'(delay_q);
			end
			ST_SUM: begin
				alu_a   = ALU_W'(dsum_q);
				alu_b   = ALU_W'(delay_q);
				alu_sub = 1'b0;
			end
			ST_BYTES: begin
				alu_a   = ALU_W'(bytes_q);
				alu_b   = ALU_W'(len_q);
				alu_sub = 1'b0;
			end
			ST_CHK, ST_ADV, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q   <= TOK_W'(TOKEN_RESET);
			timeout_q <= TMO_W'(TIMEOUT_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOKEN:   token_q   <= cfg_data[TOK_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request capture and scratch (payload, no reset)
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			len_q  <= packet_length;
			tok_q  <= packet_token;
			seq_q  <= sequence_number;
			send_q <= send_time;
			arr_q  <= arrive_time;
		end
		if (state_q == ST_CHK) begin
			thr_q   <= THR_W'(timeout_q) * THR_W'(NS_PER_MS);
			first_q <= acc_inc == CNT_W'(1);
		end
		if (state_q == ST_SET0) ptr_q <= seq_q + SEQ_W'(1);
		if (state_q == ST_ADV && ram_rdata) ptr_q <= ptr_q + SEQ_W'(1);
		if (state_q == ST_DLY) delay_q <= alu_res[DLY_W-1:0];
		if (state_q == ST_DIFF) diff_q <= alu_res;
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			exp_q     <= '0;
			acc_q     <= '0;
			bytes_q   <= '0;
			illegal_q <= '0;
			reorder_q <= '0;
			dup_q     <= '0;
			tout_q    <= '0;
			dmin_q    <= '0;
			dmax_q    <= '0;
			dsum_q    <= '0;
			verdict_q <= V_IN_ORDER;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLR: clr_q <= clr_q + SEQ_W'(1);
				ST_CHK: begin
					priority if (is_short) begin
						illegal_q <= illegal_q + CNT_W'(1);
						verdict_q <= V_SHORT;
					end else if (bad_token) begin
						illegal_q <= illegal_q + CNT_W'(1);
						verdict_q <= V_TOKEN;
					end else if (ram_rdata) begin
						dup_q     <= dup_q + CNT_W'(1);
						verdict_q <= V_DUP;
					end else begin
						acc_q <= acc_inc;
						if (seq_q != exp_q) begin
							reorder_q <= reorder_q + CNT_W'(1);
							verdict_q <= V_REORDER;
						end else begin
							verdict_q <= V_IN_ORDER;
						end
					end
				end
				ST_WALK: exp_q <= exp_q + SEQ_W'(1);
				ST_ADV: begin
					// first unseen number after this one
					if (!ram_rdata) exp_q <= ptr_q;
				end
				ST_DIFF: begin
					if (first_q) begin
						dmin_q <= delay_q;
						dmax_q <= delay_q;
					end else if (alu_neg) begin
						dmin_q <= delay_q;
					end
				end
				ST_TOUT: begin
					if (alu_neg) tout_q <= tout_q + CNT_W'(1);
				end
				ST_MAX: begin
					if (alu_neg) dmax_q <= delay_q;
				end
				ST_SUM:   dsum_q  <= alu_res[SUM_W-1:0];
				ST_BYTES: bytes_q <= alu_res[BYTES_W-1:0];
				ST_IDLE, ST_SET1, ST_SET0, ST_DLY, ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			o_verdict_q <= verdict_q;
			o_exp_q     <= exp_q;
			o_acc_q     <= acc_q;
			o_bytes_q   <= bytes_q;
			o_illegal_q <= illegal_q;
			o_reorder_q <= reorder_q;
			o_dup_q     <= dup_q;
			o_tout_q    <= tout_q;
			o_dmin_q    <= dmin_q;
			o_dmax_q    <= dmax_q;
			o_dsum_q    <= dsum_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = o_verdict_q;
	assign next_expected   = o_exp_q;
	assign accepted_count  = o_acc_q;
	assign accepted_bytes  = o_bytes_q;
	assign illegal_count   = o_illegal_q;
	assign reorder_count   = o_reorder_q;
	assign duplicate_count = o_dup_q;
	assign timeout_count   = o_tout_q;
	assign lowest_delay    = o_dmin_q;
	assign highest_delay   = o_dmax_q;
	assign delay_sum       = o_dsum_q;

endmodule
